// ===== hw/rtl/gfmi_pkg.sv =====
// gfmi_pkg: shared types, command codes and tower-field arithmetic for the
// gf(256) matrix inverse core; no dependencies
package gfmi_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // per-lane operations of the column cells
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_LOAD  = 2'd1;
   localparam logic [1:0] CELL_ACC   = 2'd2;
   localparam logic [1:0] CELL_SCALE = 2'd3;

   localparam logic [1:0] GF4_X    = 2'd2;     // x in gf(4)
   localparam logic [3:0] GF16_XY  = 4'd8;     // xy in gf(16)
   localparam logic [7:0] INV_EXP  = 8'd254;   // a^254 is the inverse
   localparam logic [7:0] GF_ONE   = 8'd1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic       is_status;
      logic       invertible;
      logic [7:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic       acc_en;
   } cell_ctl_type;

   function automatic logic [1:0] gf4_mul(input logic [1:0] a, input logic [1:0] b);
      logic [1:0] a2;
      a2 = {a[0], 1'b0} ^ (a[1] ? 2'b11 : 2'b00);
      return (b[0] ? a : 2'b00) ^ (b[1] ? a2 : 2'b00);
   endfunction

   function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
      logic [1:0] lo, hi, mid;
      lo  = gf4_mul(a[1:0], b[1:0]);
      hi  = gf4_mul(a[3:2], b[3:2]);
      mid = gf4_mul(a[1:0] ^ a[3:2], b[1:0] ^ b[3:2]) ^ lo ^ hi;
      return {mid ^ hi, lo ^ gf4_mul(hi, GF4_X)};
   endfunction

   function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
      logic [3:0] lo, hi, mid;
      lo  = gf16_mul(a[3:0], b[3:0]);
      hi  = gf16_mul(a[7:4], b[7:4]);
      mid = gf16_mul(a[3:0] ^ a[7:4], b[3:0] ^ b[7:4]) ^ lo ^ hi;
      return {mid ^ hi, lo ^ gf16_mul(hi, GF16_XY)};
   endfunction

endpackage

// ===== hw/rtl/gfmi_cell.sv =====
// gfmi_cell: one byte lane of the pivot row, holds its pivot byte and forms
// the eliminated byte for the row passing through; uses gfmi_pkg
module gfmi_cell import gfmi_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [7:0]   d_in,
   input  logic [7:0]   f_in,
   input  logic [7:0]   inv_in,
   output logic [7:0]   piv_out,
   output logic [7:0]   wr_out
);
   logic [7:0] piv_ff, piv_in;

   always_comb begin
      case (ctl.op)
         CELL_LOAD:  piv_in = d_in;
         CELL_ACC:   piv_in = ctl.acc_en ? (piv_ff ^ d_in) : piv_ff;
         CELL_SCALE: piv_in = gf256_mul(piv_ff, inv_in);
         default:    piv_in = piv_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      piv_ff <= piv_in;
   end

   assign piv_out = piv_ff;
   assign wr_out  = d_in ^ gf256_mul(piv_ff, f_in);
endmodule

// ===== hw/rtl/gfmi_inv.sv =====
// gfmi_inv: pivot inverse as a^254 by square and multiply, one product a cycle
// uses gfmi_pkg
module gfmi_inv import gfmi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] a_in,
   output logic       done,
   output logic [7:0] result
);
   logic       busy_ff, busy_in, done_ff, done_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] r_ff, r_in, a_ff, a_in_r, op_b;
   logic [2:0] bit_ix;

   always_comb begin
      bit_ix  = 3'd7 - cnt_ff[3:1];
      // even steps square, odd steps multiply by a where the exponent bit is set
      op_b    = cnt_ff[0] ? a_ff : r_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in_r  = a_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         r_in    = GF_ONE;
         a_in_r  = a_in;
      end else if (busy_ff) begin
         if (!cnt_ff[0] || INV_EXP[bit_ix]) begin
            r_in = gf256_mul(r_ff, op_b);
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'hF) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in_r;
   end

   assign done   = done_ff;
   assign result = r_ff;
endmodule

// ===== hw/rtl/gf256_matrix_inverse_core.sv =====
// gf256_matrix_inverse_core: gauss-jordan inverter over gf(256) with a row memory
// and a row of byte-lane cells; uses gfmi_pkg, gfmi_cell, gfmi_inv
//
//  channel  direction  handshake             beat
//  req_     in         req_valid/req_stall   req_type: cmd, row, col, value
//  rsp_     out        rsp_valid/rsp_stall   rsp_type: is_status, invertible, read_value
//  csr_     in         csr_valid/csr_ready   matrix_size, 7 bits
//
// a write beat reads its row, then writes it back with the new byte; a read beat reads
// its row, then waits out output back-pressure; both use the registered read of the row
// memory (one row per cycle). per pivot the later rows stream through the cells once to
// fold, the inverter inverts the pivot, and all other rows stream once to eliminate.
// reset is synchronous; it clears control state, the flag and sets size to 64.
// the memory contents are undefined until written. req_stall is high while busy.
module gf256_matrix_inverse_core import gfmi_pkg::*; #(
   parameter int MAX_N = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);
   localparam int NC  = 2 * MAX_N;
   localparam int RW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW  = $clog2(MAX_N + 1);
   localparam int CIW = $clog2(NC);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRMOD = 4'd1;
   localparam logic [3:0] ST_RDGET = 4'd2;
   localparam logic [3:0] ST_RESP  = 4'd3;
   localparam logic [3:0] ST_INIT  = 4'd4;
   localparam logic [3:0] ST_PLOAD = 4'd5;
   localparam logic [3:0] ST_PGET  = 4'd6;
   localparam logic [3:0] ST_ACC   = 4'd7;
   localparam logic [3:0] ST_INV   = 4'd8;
   localparam logic [3:0] ST_WRPIV = 4'd9;
   localparam logic [3:0] ST_ELIM  = 4'd10;

   typedef logic [NC-1:0][7:0] row_vec_type;

   row_vec_type mem [MAX_N];
   row_vec_type rd_q_ff, wd, piv_row, wr_row;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, n;
   logic          arr_ff, arr_in;
   logic [RW-1:0] arr_row_ff, arr_row_in, wrow_ff, wrow_in, ra, wa;
   logic [5:0]    col_ff, col_in;
   logic [7:0]    val_ff, val_in;
   logic          inr_ff, inr_in, ok_ff, ok_in, flag_ff, flag_in;
   logic [6:0]    size_ff, size_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in, pend_ff, pend_in;
   logic          re, we, req_acc, req_inr, issue;
   logic [7:0]    pivot, f_byte;
   logic          inv_start, inv_done;
   logic [7:0]    inv_val;
   cell_ctl_type  cell_ctl;
   logic [NC-1:0] lane_use;

   // size in use, clamped to 1..MAX_N
   always_comb begin
      if (size_ff == 7'd0) begin
         n = CW'(1);
      end else if ({1'b0, size_ff} > 8'(MAX_N)) begin
         n = CW'(MAX_N);
      end else begin
         n = CW'(size_ff);
      end
   end

   // lanes of both halves that lie inside the size in use
   always_comb begin
      for (int k = 0; k < MAX_N; k++) begin
         lane_use[k]         = (CW'(k) < n);
         lane_use[MAX_N + k] = (CW'(k) < n);
      end
   end

   assign req_acc = req_valid && !req_stall;
   assign req_inr = (8'(req_data.row) < 8'(n)) && (8'(req_data.col) < 8'(n));
   assign pivot   = piv_row[CIW'(i_ff)];
   assign f_byte  = rd_q_ff[CIW'(i_ff)];

   genvar g;
   generate
      for (g = 0; g < NC; g++) begin : g_cell
         cell_ctl_type ctl_g;
         // lanes outside the size in use load the row but never change it
         assign ctl_g.op     = (lane_use[g] || cell_ctl.op == CELL_LOAD) ? cell_ctl.op
                                                                         : CELL_HOLD;
         assign ctl_g.acc_en = cell_ctl.acc_en;
         gfmi_cell u_cell (
            .clock   (clock),
            .ctl     (ctl_g),
            .d_in    (rd_q_ff[g]),
            .f_in    (f_byte),
            .inv_in  (inv_val),
            .piv_out (piv_row[g]),
            .wr_out  (wr_row[g])
         );
      end
   endgenerate

   gfmi_inv u_inv (
      .clock  (clock),
      .reset  (reset),
      .start  (inv_start),
      .a_in   (pivot),
      .done   (inv_done),
      .result (inv_val)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      wrow_in      = wrow_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      inr_in       = inr_ff;
      ok_in        = ok_ff;
      flag_in      = flag_ff;
      size_in      = size_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      re           = 1'b0;
      ra           = '0;
      we           = 1'b0;
      wa           = arr_row_ff;
      wd           = rd_q_ff;
      issue        = 1'b0;
      inv_start    = 1'b0;
      cell_ctl     = '{op: CELL_HOLD, acc_en: 1'b0};

      if (csr_valid && csr_ready) begin
         size_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ra      = RW'(req_data.row);
               wrow_in = RW'(req_data.row);
               col_in  = req_data.col;
               val_in  = req_data.value;
               inr_in  = req_inr;
               case (req_data.cmd)
                  CMD_WRITE: begin
                     if (req_inr) begin
                        re       = 1'b1;
                        state_in = ST_WRMOD;
                     end
                  end
                  CMD_READ: begin
                     re       = 1'b1;
                     state_in = ST_RDGET;
                  end
                  CMD_RUN: begin
                     i_in     = '0;
                     j_in     = '0;
                     ok_in    = 1'b1;
                     state_in = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_WRMOD: begin
            we                  = 1'b1;
            wa                  = wrow_ff;
            wd[CIW'(col_ff)]    = val_ff;
            state_in            = ST_IDLE;
         end
         ST_RDGET: begin
            pend_in.is_status  = 1'b0;
            pend_in.invertible = flag_ff;
            pend_in.read_value = inr_ff ? rd_q_ff[CIW'(MAX_N) + CIW'(col_ff)] : 8'd0;
            state_in           = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_INIT: begin
            // right half of each row in use becomes the identity row
            if (j_ff < n) begin
               re    = 1'b1;
               issue = 1'b1;
               ra    = RW'(j_ff);
               j_in  = j_ff + CW'(1);
            end
            if (arr_ff) begin
               we = 1'b1;
               for (int k = 0; k < MAX_N; k++) begin
                  if (CW'(k) < n) begin
                     wd[MAX_N + k] = (RW'(k) == arr_row_ff) ? GF_ONE : 8'd0;
                  end
               end
            end
            if (j_ff == n && !arr_ff) begin
               state_in = ST_PLOAD;
            end
         end
         ST_PLOAD: begin
            re       = 1'b1;
            ra       = RW'(i_ff);
            state_in = ST_PGET;
         end
         ST_PGET: begin
            cell_ctl.op = CELL_LOAD;
            j_in        = i_ff + CW'(1);
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            // later rows fold in only while the pivot is still zero
            if (j_ff < n) begin
               re    = 1'b1;
               issue = 1'b1;
               ra    = RW'(j_ff);
               j_in  = j_ff + CW'(1);
            end
            if (arr_ff) begin
               cell_ctl.op     = CELL_ACC;
               cell_ctl.acc_en = (pivot == 8'd0);
            end
            if (j_ff == n && !arr_ff) begin
               inv_start = 1'b1;
               if (pivot == 8'd0) begin
                  ok_in = 1'b0;
               end
               state_in = ST_INV;
            end
         end
         ST_INV: begin
            if (inv_done) begin
               cell_ctl.op = CELL_SCALE;
               state_in    = ST_WRPIV;
            end
         end
         ST_WRPIV: begin
            we       = 1'b1;
            wa       = RW'(i_ff);
            wd       = piv_row;
            j_in     = '0;
            state_in = ST_ELIM;
         end
         ST_ELIM: begin
            if (j_ff < n) begin
               if (j_ff != i_ff) begin
                  re    = 1'b1;
                  issue = 1'b1;
               end
               ra   = RW'(j_ff);
               j_in = j_ff + CW'(1);
            end
            if (arr_ff) begin
               we = 1'b1;
               for (int k = 0; k < NC; k++) begin
                  if (lane_use[k]) begin
                     wd[k] = wr_row[k];
                  end
               end
            end
            if (j_ff == n && !arr_ff) begin
               if (i_ff + CW'(1) == n) begin
                  flag_in            = ok_ff;
                  pend_in.is_status  = 1'b1;
                  pend_in.invertible = ok_ff;
                  pend_in.read_value = 8'd0;
                  state_in           = ST_RESP;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = ST_PLOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      arr_in     = issue;
      arr_row_in = ra;
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_q_ff <= mem[ra];
      end
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         arr_ff       <= 1'b0;
         flag_ff      <= 1'b0;
         size_ff      <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         arr_ff       <= arr_in;
         flag_ff      <= flag_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      arr_row_ff <= arr_row_in;
      wrow_ff    <= wrow_in;
      col_ff     <= col_in;
      val_ff     <= val_in;
      inr_ff     <= inr_in;
      ok_ff      <= ok_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_arr_row: assert property (@(posedge clock) disable iff (reset)
      arr_ff |-> (CW'(arr_row_ff) < n))
      else $error("row arriving from memory lies outside the size in use");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_status) |-> (rsp_ff.read_value == 8'd0))
      else $error("status beat carries read data");
   a_inv_state: assert property (@(posedge clock) disable iff (reset)
      inv_done |-> (state_ff == ST_INV))
      else $error("inverter finished outside the inverse wait");
   a_pivot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INV || state_ff == ST_ELIM) |-> (i_ff < n))
      else $error("pivot row index beyond size in use");
endmodule

// ===== dv/gf256_matrix_inverse_core_tb.sv =====
// gf256_matrix_inverse_core_tb: self-checking bench for the gf(256) matrix inverter;
// queue-fed driver, always-block monitor and a gauss-jordan predictor over the tower field
// depends on gfmi_pkg (beat types, command codes) and gf256_matrix_inverse_core
module gf256_matrix_inverse_core_tb;
   import gfmi_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int MAX_N      = 64;
   localparam int DRAIN      = 16;
   localparam int CALM_TAIL  = 150;
   localparam int CYCLE_CAP  = 4000000;

   typedef struct {
      bit         is_cfg;
      logic [6:0] size;
      req_type    beat;
   } stim_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = 7'd0;

   stim_type   pending[$];
   rsp_type    awaited_rsp[$];

   // predictor state
   logic [7:0] aug_mat[MAX_N][2*MAX_N];
   logic       inv_flag;
   logic [6:0] size_reg;

   int errors = 0;
   int cycles = 0;
   int n_runs = 0, n_ok_runs = 0, n_reads = 0, n_cfg = 0, n_beats = 0;

   gf256_matrix_inverse_core #(.MAX_N(MAX_N)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tower field arithmetic
   function automatic logic [1:0] mul4(input logic [1:0] a, input logic [1:0] b);
      logic [1:0] ax;
      ax = {a[0] ^ a[1], a[1]};
      return (b[0] ? a : 2'b00) ^ (b[1] ? ax : 2'b00);
   endfunction

   function automatic logic [3:0] mul16(input logic [3:0] a, input logic [3:0] b);
      logic [1:0] l, h, m;
      l = mul4(a[1:0], b[1:0]);
      h = mul4(a[3:2], b[3:2]);
      m = mul4(a[1:0] ^ a[3:2], b[1:0] ^ b[3:2]) ^ l ^ h;
      return {m ^ h, l ^ mul4(h, 2'b10)};
   endfunction

   function automatic logic [7:0] mul256(input logic [7:0] a, input logic [7:0] b);
      logic [3:0] l, h, m;
      l = mul16(a[3:0], b[3:0]);
      h = mul16(a[7:4], b[7:4]);
      m = mul16(a[3:0] ^ a[7:4], b[3:0] ^ b[7:4]) ^ l ^ h;
      return {m ^ h, l ^ mul16(h, 4'h8)};
   endfunction

   function automatic logic [7:0] recip256(input logic [7:0] a);
      logic [7:0] r;
      r = 8'd1;
      for (int b = 7; b >= 0; b--) begin
         r = mul256(r, r);
         if (b != 0) r = mul256(r, a);
      end
      return r;
   endfunction

   function automatic int order_of(input logic [6:0] v);
      if (v == 0) return 1;
      if (v > MAX_N) return MAX_N;
      return int'(v);
   endfunction

   function automatic int lane(input int k, input int n);
      return (k < n) ? k : MAX_N + k - n;
   endfunction

   function automatic logic invert_matrix(input int n);
      logic       ok;
      logic [7:0] piv, f;
      ok = 1'b1;
      for (int i = 0; i < n; i++)
         for (int k = 0; k < n; k++)
            aug_mat[i][MAX_N+k] = (k == i) ? 8'd1 : 8'd0;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++)
            if (aug_mat[i][i] == 0)
               for (int k = 0; k < 2*n; k++)
                  aug_mat[i][lane(k, n)] ^= aug_mat[j][lane(k, n)];
         if (aug_mat[i][i] == 0) ok = 1'b0;
         piv = recip256(aug_mat[i][i]);
         for (int k = 0; k < 2*n; k++)
            aug_mat[i][lane(k, n)] = mul256(aug_mat[i][lane(k, n)], piv);
         for (int j = 0; j < n; j++) begin
            if (j == i) continue;
            f = aug_mat[j][i];
            for (int k = 0; k < 2*n; k++)
               aug_mat[j][lane(k, n)] ^= mul256(aug_mat[i][lane(k, n)], f);
         end
      end
      return ok;
   endfunction

   task automatic predict_beat(input req_type b);
      rsp_type r;
      int      n;
      n = order_of(size_reg);
      r = '0;
      case (b.cmd)
         CMD_WRITE: begin
            if (b.row < n && b.col < n) aug_mat[b.row][b.col] = b.value;
         end
         CMD_RUN: begin
            inv_flag = invert_matrix(n);
            r.is_status = 1'b1;
            r.invertible = inv_flag;
            awaited_rsp.push_back(r);
            n_runs++;
            if (inv_flag) n_ok_runs++;
         end
         CMD_READ: begin
            r.invertible = inv_flag;
            r.read_value = (b.row < n && b.col < n) ? aug_mat[b.row][MAX_N+b.col] : 8'd0;
            awaited_rsp.push_back(r);
            n_reads++;
         end
         default: ;
      endcase
   endtask

   // stimulus helpers
   task automatic add_beat(input logic [1:0] c, input int r, input int k, input int v);
      stim_type s;
      s.is_cfg = 1'b1 ^ 1'b1;
      s.size = '0;
      s.beat.cmd = c;
      s.beat.row = r[5:0];
      s.beat.col = k[5:0];
      s.beat.value = v[7:0];
      pending.push_back(s);
      n_beats++;
   endtask

   task automatic add_cfg(input int v);
      stim_type s;
      s.is_cfg = 1'b1;
      s.size = v[6:0];
      s.beat = '0;
      pending.push_back(s);
   endtask

   // load a full matrix, run, then read back; shape picks the flavour of matrix
   task automatic matrix_phase(input int cfg_val, input int shape, input int reads);
      int         n, r, k;
      logic [7:0] m[MAX_N][MAX_N];
      n = order_of(cfg_val[6:0]);
      add_cfg(cfg_val);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            case (shape)
               1: m[i][j] = (i == j) ? 8'd1 : 8'd0;
               2: m[i][j] = 8'd0;
               default: m[i][j] = 8'($urandom_range(0, 255));
            endcase
      if (shape == 3 && n > 1) begin
         // repeated row: singular
         r = $urandom_range(1, n - 1);
         for (int j = 0; j < n; j++) m[r][j] = m[0][j];
      end
      if (shape == 4 && n > 1) begin
         // zero pivot up front forces the row-combine path
         for (int i = 0; i < n - 1; i++) m[i][i] = 8'd0;
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            add_beat(CMD_WRITE, i, j, m[i][j]);
            if ($urandom_range(0, 19) == 0)
               add_beat(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255));
            if (n < MAX_N && $urandom_range(0, 15) == 0)
               add_beat(CMD_WRITE, $urandom_range(n, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255));
         end
      add_beat(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      for (int q = 0; q < reads; q++) begin
         if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(0, 63);
            k = (n < MAX_N) ? $urandom_range(n, 63) : $urandom_range(0, 63);
         end else begin
            r = $urandom_range(0, n - 1);
            k = $urandom_range(0, n - 1);
         end
         add_beat(CMD_READ, r, k, $urandom_range(0, 255));
      end
   endtask

   // driver
   int  gap = 0;
   int  quiet = 0;
   bit  idle_mode = 1'b1;

   always @(posedge clock) begin
      logic     req_hold, csr_hold, req_took, nv_req, nv_csr;
      stim_type s;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         req_took = req_valid && !req_stall;
         req_hold = req_valid && req_stall;
         csr_hold = csr_valid && !csr_ready;
         if (req_took || awaited_rsp.size() != 0) quiet = 0;
         else if (quiet < DRAIN) quiet++;
         if (!req_hold && !csr_hold) begin
            nv_req = 1'b0;
            nv_csr = 1'b0;
            if (gap > 0) gap--;
            else if (pending.size() != 0) begin
               if (pending[0].is_cfg) begin
                  // only write the size once the core has fully drained
                  if (quiet >= DRAIN && !csr_valid) begin
                     s = pending.pop_front();
                     csr_data <= s.size;
                     nv_csr = 1'b1;
                  end
               end else begin
                  s = pending.pop_front();
                  req_data <= s.beat;
                  nv_req = 1'b1;
                  if ($urandom_range(0, 99) == 0) idle_mode = !idle_mode;
                  if (idle_mode && pending.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                     gap = $urandom_range(1, 11);
               end
            end
            req_valid <= nv_req;
            csr_valid <= nv_csr;
         end
      end
   end

   // result side back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (pending.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= 1'b0;
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         inv_flag = 1'b0;
         size_reg = 7'd64;
      end else begin
         if (csr_valid && csr_ready) begin
            size_reg = csr_data;
            n_cfg++;
         end
         if (req_valid && !req_stall) predict_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.is_status !== want.is_status) begin
                  $display("%0t: is_status expected %0d actual %0d", $time,
                           want.is_status, rsp_data.is_status);
                  errors++;
               end
               if (rsp_data.invertible !== want.invertible) begin
                  $display("%0t: invertible expected %0d actual %0d", $time,
                           want.invertible, rsp_data.invertible);
                  errors++;
               end
               if (rsp_data.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %02h actual %02h", $time,
                           want.read_value, rsp_data.read_value);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  awaited_rsp.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAX_N; i++)
         for (int j = 0; j < 2*MAX_N; j++)
            aug_mat[i][j] = 8'd0;
      // directed: 1x1 corner cases, size clamping, spare command, zero pivot
      add_cfg(1);
      add_beat(CMD_WRITE, 0, 0, 0);
      add_beat(CMD_RUN, 0, 0, 0);
      add_beat(CMD_READ, 0, 0, 0);
      add_beat(CMD_WRITE, 0, 0, 255);
      add_beat(CMD_WRITE, 63, 63, 170);
      add_beat(CMD_SPARE, 63, 63, 255);
      add_beat(CMD_RUN, 63, 63, 255);
      add_beat(CMD_READ, 0, 0, 0);
      add_beat(CMD_READ, 63, 63, 255);
      add_beat(CMD_READ, 0, 63, 0);
      matrix_phase(0, 0, 2);
      matrix_phase(2, 4, 4);
      matrix_phase(3, 2, 3);
      // random phases, mostly small orders
      while (n_beats < 1800) begin
         int v, shape;
         case ($urandom_range(0, 9))
            0:       v = $urandom_range(9, 16);
            1:       v = 0;
            default: v = $urandom_range(1, 8);
         endcase
         shape = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
         matrix_phase(v, shape, $urandom_range(3, 2 * order_of(v[6:0]) + 4));
      end
      // over-range size clamps to the top size; read back the last inverse under it
      matrix_phase(5, 0, 30);
      add_cfg(127);
      for (int q = 0; q < 12; q++)
         add_beat(CMD_READ, $urandom_range(0, 4), $urandom_range(0, 4), 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid && !csr_valid && awaited_rsp.size() == 0);
      repeat (60) @(posedge clock);
      $display("covered %0d beats, %0d size writes, %0d runs (%0d invertible), %0d reads",
               n_beats, n_cfg, n_runs, n_ok_runs, n_reads);
      if (errors == 0 && awaited_rsp.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
